// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared payload types, round constants, initial hash words and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // What to put into the block buffer on a write cycle.
    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_BYTE = 2'd1,
        WR_PAD  = 2'd2,
        WR_LEN  = 2'd3
    } t_wr_op;

    typedef struct packed {
        t_wr_op     wr_op;
        logic [7:0] wr_byte;
        logic       count_byte;   // advance position and message length
        logic       round_start;  // load working variables from chain hash
        logic       round_step;   // run one round
        logic       round_finish; // add working variables into chain hash
        logic       zero_block;   // clear the whole block buffer
        logic       chain_init;   // reload the initial hash, clear counters
        logic       out_shift;    // rotate the chain hash for output
    } t_sha_cmd;

    typedef struct packed {
        logic       block_full;   // position wrapped to zero after a byte
        logic [5:0] position;
        logic       last_round;
    } t_sha_sts;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message taken one byte per word and returns the eight digest
// words, most significant first.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     i_valid, o_ready, i_data         in
//  output    o_valid, i_ready, o_data         out
//
//  A byte that does not fill the block is written in S_IDLE and checked in S_CHECK.
//  A byte that fills the block adds a compression: one round per cycle in the
//  shared round unit, plus load and add-back.
//  The last word adds padding (with an extra compression if the pad lands at 56 or beyond),
//  one compression and the eight output words, each stalled while i_ready is low.
//  Reset is synchronous: it restores the initial hash and clears the counters on a clock edge.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sha_pkg::t_out_word  o_data
);

    sha_pkg::t_sha_cmd cmd;
    sha_pkg::t_sha_sts sts;
    logic [31:0]       digest;
    logic [2:0]        idx;

    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_out_ready  (i_ready),
        .o_out_valid  (o_valid),
        .o_word_index (idx),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    sha_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_digest_word (digest)
    );

    assign o_data.digest_word = digest;
    assign o_data.word_index  = idx;
    assign o_data.last_word   = (idx == 3'd7);

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshakes overlap");
    a_round_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.round_step && cmd.wr_op != sha_pkg::WR_NONE))
        else $error("block write during a round");
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && idx != 3'd7) |=> (o_valid && idx == $past(idx) + 3'd1))
        else $error("digest words out of order");
`endif

endmodule

// ===== hw/rtl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule window, one round unit, chain hash,
// byte position and message length.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_sha_cmd  i_cmd,
    output sha_pkg::t_sha_sts  o_sts,
    output logic [31:0]        o_digest_word
);

    logic [31:0] r_blk [16];
    logic [31:0] r_hash [8];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]  r_pos;
    logic [60:0] r_msg_bytes;
    logic [5:0]  r_round;

    logic [31:0] w_now, s0, s1, w_new, t1, t2, sig1, sig0, ch, mj;
    logic [63:0] bit_len;

    assign bit_len = {r_msg_bytes, 3'b000};

    // The block buffer doubles as the schedule window: word 0 is W[t].
    assign w_now = r_blk[0];
    assign s0 = {r_blk[1][6:0], r_blk[1][31:7]} ^ {r_blk[1][17:0], r_blk[1][31:18]}
              ^ (r_blk[1] >> 3);
    assign s1 = {r_blk[14][16:0], r_blk[14][31:17]}
              ^ {r_blk[14][18:0], r_blk[14][31:19]} ^ (r_blk[14] >> 10);
    assign w_new = s1 + r_blk[9] + s0 + r_blk[0];

    assign sig1 = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]}
                ^ {r_e[24:0], r_e[31:25]};
    assign ch   = (r_e & r_f) ^ (~r_e & r_g);
    assign t1   = r_h + sig1 + ch + sha_pkg::round_k(r_round) + w_now;
    assign sig0 = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]}
                ^ {r_a[21:0], r_a[31:22]};
    assign mj   = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2   = sig0 + mj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_block) begin
            for (int i = 0; i < 16; i++) r_blk[i] <= '0;
        end else if (i_cmd.round_step) begin
            for (int i = 0; i < 15; i++) r_blk[i] <= r_blk[i+1];
            r_blk[15] <= w_new;
        end else begin
            unique case (i_cmd.wr_op)
                sha_pkg::WR_BYTE, sha_pkg::WR_PAD: begin
                    r_blk[r_pos[5:2]][8*(3-r_pos[1:0]) +: 8] <= i_cmd.wr_byte;
                    // Padding clears the rest of the current word and all later words.
                    if (i_cmd.wr_op == sha_pkg::WR_PAD) begin
                        unique case (r_pos[1:0])
                            2'd0: r_blk[r_pos[5:2]][23:0] <= '0;
                            2'd1: r_blk[r_pos[5:2]][15:0] <= '0;
                            2'd2: r_blk[r_pos[5:2]][7:0]  <= '0;
                            default: ;
                        endcase
                        for (int i = 0; i < 16; i++) begin
                            if (4'(i) > r_pos[5:2]) r_blk[i] <= '0;
                        end
                    end
                end
                sha_pkg::WR_LEN: begin
                    r_blk[14] <= bit_len[63:32];
                    r_blk[15] <= bit_len[31:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_start) begin
            {r_a, r_b, r_c, r_d} <= {r_hash[0], r_hash[1], r_hash[2], r_hash[3]};
            {r_e, r_f, r_g, r_h} <= {r_hash[4], r_hash[5], r_hash[6], r_hash[7]};
        end else if (i_cmd.round_step) begin
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chain_init) begin
            for (int i = 0; i < 8; i++) r_hash[i] <= sha_pkg::init_hash(3'(i));
            r_pos       <= '0;
            r_msg_bytes <= '0;
        end else begin
            if (i_cmd.round_finish) begin
                r_hash[0] <= r_hash[0] + r_a; r_hash[1] <= r_hash[1] + r_b;
                r_hash[2] <= r_hash[2] + r_c; r_hash[3] <= r_hash[3] + r_d;
                r_hash[4] <= r_hash[4] + r_e; r_hash[5] <= r_hash[5] + r_f;
                r_hash[6] <= r_hash[6] + r_g; r_hash[7] <= r_hash[7] + r_h;
            end else if (i_cmd.out_shift) begin
                for (int i = 0; i < 7; i++) r_hash[i] <= r_hash[i+1];
                r_hash[7] <= r_hash[0];
            end
            if (i_cmd.count_byte) begin
                r_pos       <= r_pos + 6'd1;
                r_msg_bytes <= r_msg_bytes + 61'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.round_start) r_round <= '0;
        else if (i_cmd.round_step)         r_round <= r_round + 6'd1;
    end

    assign o_sts.block_full = (r_pos == 6'd0);
    assign o_sts.position   = r_pos;
    assign o_sts.last_round = (r_round == 6'd63);
    assign o_digest_word    = r_hash[0];

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte writes, compressions, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_word  i_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_word_index,
    output sha_pkg::t_sha_cmd  o_cmd,
    input  sha_pkg::t_sha_sts  i_sts
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_START  = 8'b0000_0100,
        S_ROUND  = 8'b0000_1000,
        S_FINISH = 8'b0001_0000,
        S_PAD    = 8'b0010_0000,
        S_LEN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    // Which step follows a compression.
    typedef enum logic [1:0] {
        AFTER_IDLE = 2'd0,
        AFTER_PAD  = 2'd1,
        AFTER_LEN  = 2'd2,
        AFTER_OUT  = 2'd3
    } t_after;

    t_state      r_state, n_state;
    t_after      r_after, n_after;
    logic        r_last, n_last;
    logic [2:0]  r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= AFTER_IDLE;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_idx;

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_last  = r_last;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.wr_op = sha_pkg::WR_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_data.last;
                    if (i_data.has_byte) begin
                        o_cmd.wr_op      = sha_pkg::WR_BYTE;
                        o_cmd.wr_byte    = i_data.data_byte;
                        o_cmd.count_byte = 1'b1;
                        n_state = S_CHECK;
                    end else if (i_data.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_CHECK: begin
                // A byte that fills the block starts a compression.
                if (i_sts.block_full) begin
                    n_after = r_last ? AFTER_PAD : AFTER_IDLE;
                    n_state = S_START;
                end else begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end
            end
            S_START: begin
                o_cmd.round_start = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_sts.last_round) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.round_finish = 1'b1;
                unique case (r_after)
                    AFTER_IDLE: n_state = S_IDLE;
                    AFTER_PAD:  n_state = S_PAD;
                    AFTER_LEN:  n_state = S_LEN;
                    default:    n_state = S_OUT;
                endcase
                if (r_after == AFTER_LEN) o_cmd.zero_block = 1'b1;
            end
            S_PAD: begin
                o_cmd.wr_op   = sha_pkg::WR_PAD;
                o_cmd.wr_byte = sha_pkg::PAD_BYTE;
                if (i_sts.position >= 6'd56) begin
                    n_after = AFTER_LEN;
                    n_state = S_START;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.wr_op = sha_pkg::WR_LEN;
                n_after = AFTER_OUT;
                n_idx   = '0;
                n_state = S_START;
            end
            default: begin
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.out_shift  = 1'b0;
                        o_cmd.chain_init = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

// ===== tb/sha256_byte_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams messages into the hasher byte by byte, predicts each digest with a
// behavioral SHA-256 model and compares every output word in order.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    sha_pkg::t_in_word   i_data;
    logic                o_valid;
    logic                i_ready;
    sha_pkg::t_out_word  o_data;

    sha256_byte_stream_hasher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Hash state of the prediction.
    logic [31:0] hash_q [8];
    logic [31:0] blk_q [16];
    logic [5:0]  pos_q;
    logic [60:0] len_q;

    sha_pkg::t_in_word  byte_queue [$];
    sha_pkg::t_out_word digest_queue [$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                w[i] = blk_q[i];
            end else begin
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            end
        end
        v = hash_q;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_q[i] = hash_q[i] + v[i];
    endtask

    task automatic put_byte(input int p, input logic [7:0] b);
        blk_q[p / 4][31 - 8 * (p % 4) -: 8] = b;
    endtask

    task automatic predict_digest(input sha_pkg::t_in_word w);
        logic [63:0]        bits;
        sha_pkg::t_out_word o;
        if (w.has_byte) begin
            put_byte(pos_q, w.data_byte);
            pos_q++;
            len_q++;
            if (pos_q == 0) compress();
        end
        if (w.last) begin
            bits = {len_q, 3'b000};
            put_byte(pos_q, sha_pkg::PAD_BYTE);
            for (int p = pos_q + 1; p < 64; p++) put_byte(p, 8'h00);
            if (pos_q >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) blk_q[i] = '0;
            end
            blk_q[14] = bits[63:32];
            blk_q[15] = bits[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_q[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_queue.push_back(o);
            end
            hash_q = H0;
            pos_q  = '0;
            len_q  = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic sha_pkg::t_in_word mk(input logic [7:0] b, input logic hb,
                                             input logic l);
        sha_pkg::t_in_word w;
        w.data_byte = b; w.has_byte = hb; w.last = l;
        return w;
    endfunction

    task automatic add_message(input int n, input logic tail_empty);
        for (int i = 0; i < n; i++) begin
            byte_queue.push_back(mk(8'($urandom), 1'b1,
                                    (i == n - 1) && !tail_empty));
            // Occasional byte-less filler inside a message.
            if ($urandom_range(0, 15) == 0) byte_queue.push_back(mk(8'($urandom), 1'b0, 1'b0));
        end
        if (tail_empty || n == 0) byte_queue.push_back(mk(8'($urandom), 1'b0, 1'b1));
    endtask

    // Driver: one word per accepted handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_digest(i_data);
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data  <= byte_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        sha_pkg::t_out_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected word", o_data.digest_word, 32'h0);
                end else begin
                    want = digest_queue.pop_front();
                    if (o_data.digest_word !== want.digest_word)
                        report_mismatch("digest_word", o_data.digest_word, want.digest_word);
                    if (o_data.word_index !== want.word_index)
                        report_mismatch("word_index", o_data.word_index, want.word_index);
                    if (o_data.last_word !== want.last_word)
                        report_mismatch("last_word", o_data.last_word, want.last_word);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;
        error_count = 0;
        hash_q = H0;
        for (int i = 0; i < 16; i++) blk_q[i] = '0;
        pos_q = '0;
        len_q = '0;
        send_idle_pct = 21;
        recv_idle_pct = 72;

        // Directed: empty message, extremes of the byte, idle filler.
        byte_queue.push_back(mk(8'hff, 1'b0, 1'b1));
        byte_queue.push_back(mk(8'h5a, 1'b0, 1'b0));
        byte_queue.push_back(mk(8'h00, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'hff, 1'b1, 1'b1));
        byte_queue.push_back(mk(8'haa, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h55, 1'b0, 1'b1));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length that needs an extra block, and a full block before the end.
        add_message(56, 1'b0);
        add_message(64, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 72;
                recv_idle_pct = 21;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // A few short random messages in each phase.
            for (int m = 0; m < 3; m++) begin
                add_message($urandom_range(0, 5), $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0) byte_queue.push_back(mk(8'($urandom), 1'b0, 1'b0));
            end
            // Sample away from the driving edge so that queue and valid have settled.
            @(negedge i_clk);
            while (byte_queue.size() > 0 || i_valid || digest_queue.size() > 0)
                @(negedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_datapath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_tb.sv
